@@ hdl/i2c_register_master_unit_macros.svh @@
// Assertion helpers for the checker file.
`ifndef I2C_REGISTER_MASTER_UNIT_MACROS_SVH
`define I2C_REGISTER_MASTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/i2crm_pkg.sv @@
`default_nettype none
package i2crm_pkg;

  // Input word: one bus tick
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  register_pointer;
    logic [15:0] write_data;
    logic        scl_in;
    logic        sda_in;
  } in_word_t;

  // Result word: line drives and status after the tick
  typedef struct packed {
    logic        scl_drive_low;
    logic        sda_drive_low;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  half_period_ticks;
    logic [15:0] stretch_timeout_ticks;
    logic [6:0]  device_address;
  } cfg_t;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_STRETCH_TO  = 2'd1;
  localparam logic [1:0] CFG_DEV_ADDR    = 2'd2;

  localparam logic [9:0]  HALF_PERIOD_RST = 10'd48;
  localparam logic [15:0] STRETCH_TO_RST  = 16'd2000;
  localparam logic [6:0]  DEV_ADDR_RST    = 7'd64;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RECOVER = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NACK    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TM_IDLE  = 2'd0,
    TM_RUN   = 2'd1,
    TM_DELAY = 2'd2,
    TM_WAIT  = 2'd3
  } timing_t;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_START_BEGIN = 5'd1,
    PH_START_2     = 5'd2,
    PH_START_3     = 5'd3,
    PH_NEXT        = 5'd4,
    PH_WB_BEGIN    = 5'd5,
    PH_WB_BIT      = 5'd6,
    PH_WB_CLK      = 5'd7,
    PH_WB_CLKED    = 5'd8,
    PH_WB_AFTER    = 5'd9,
    PH_ACK_CLK     = 5'd10,
    PH_ACK_SAMPLE  = 5'd11,
    PH_ACK_DONE    = 5'd12,
    PH_RB_BEGIN    = 5'd13,
    PH_RB_CLK      = 5'd14,
    PH_RB_SAMPLE   = 5'd15,
    PH_RB_AFTER    = 5'd16,
    PH_RB_ACLK     = 5'd17,
    PH_RB_ADONE    = 5'd18,
    PH_RB_END      = 5'd19,
    PH_STOP        = 5'd20,
    PH_STOP_2      = 5'd21,
    PH_STOP_3      = 5'd22,
    PH_FINISH      = 5'd23,
    PH_RC_BEGIN    = 5'd24,
    PH_RC_TEST     = 5'd25,
    PH_RC_CLKED    = 5'd26,
    PH_RC_AFTER    = 5'd27
  } phase_t;

endpackage
`default_nettype wire

@@ hdl/i2crm_seq.sv @@
`default_nettype none
module i2crm_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire i2crm_pkg::in_word_t in_word,
  input  wire i2crm_pkg::cfg_t     cfg,
  output i2crm_pkg::out_word_t     res_nxt
);

  typedef struct packed {
    i2crm_pkg::phase_t  phase;
    i2crm_pkg::timing_t timing;
    logic [3:0]         bit_count;
    logic [2:0]         byte_index;
    logic [7:0]         shift_byte;
    logic [15:0]        tick_timer;
    logic [1:0]         lcmd;
    logic [7:0]         lptr;
    logic [15:0]        ldata;
    logic [15:0]        rxval;
    logic [1:0]         status;
    logic               stretch_fail;
    logic               scl_low;
    logic               sda_low;
    logic               done;
  } seq_state_t;

  seq_state_t st_r, st_nxt;
  logic [15:0] hold_val;
  logic [15:0] limit;

  assign hold_val = (cfg.half_period_ticks == 10'd0) ? 16'd1
                                                     : {6'd0, cfg.half_period_ticks};
  assign limit = (cfg.stretch_timeout_ticks == 16'd0) ? 16'd1 : cfg.stretch_timeout_ticks;

  function automatic seq_state_t go_f(input seq_state_t s, input i2crm_pkg::phase_t ph);
    seq_state_t r;
    r = s;
    r.timing = i2crm_pkg::TM_RUN;
    r.phase = ph;
    return r;
  endfunction

  function automatic seq_state_t hold_f(input seq_state_t s, input i2crm_pkg::phase_t ph,
                                        input logic [15:0] hv);
    seq_state_t r;
    r = s;
    r.tick_timer = hv;
    r.timing = i2crm_pkg::TM_DELAY;
    r.phase = ph;
    return r;
  endfunction

  function automatic seq_state_t rel_f(input seq_state_t s, input i2crm_pkg::phase_t ph);
    seq_state_t r;
    r = s;
    r.scl_low = 1'b0;
    r.tick_timer = 16'd0;
    r.stretch_fail = 1'b0;
    r.timing = i2crm_pkg::TM_WAIT;
    r.phase = ph;
    return r;
  endfunction

  function automatic seq_state_t wbyte_f(input seq_state_t s, input logic [7:0] b);
    seq_state_t r;
    r = s;
    r.shift_byte = b;
    return go_f(r, i2crm_pkg::PH_WB_BEGIN);
  endfunction

  // One zero-duration action of the bus sequencer
  function automatic seq_state_t run_action(input seq_state_t s, input logic sda,
                                            input logic [6:0] dev, input logic [15:0] hv);
    seq_state_t r;
    logic [7:0] addr;
    r = s;
    addr = {dev, 1'b0};
    case (s.phase)
      i2crm_pkg::PH_START_BEGIN: begin
        r.sda_low = 1'b0;
        r = rel_f(r, i2crm_pkg::PH_START_2);
      end
      i2crm_pkg::PH_START_2: begin
        if (s.stretch_fail) begin
          r.status = i2crm_pkg::ST_TIMEOUT;
          // a failed first start skips the stop
          r = go_f(r, (s.byte_index == 3'd0) ? i2crm_pkg::PH_FINISH : i2crm_pkg::PH_STOP);
        end else begin
          r.sda_low = 1'b1;
          r = hold_f(r, i2crm_pkg::PH_START_3, hv);
        end
      end
      i2crm_pkg::PH_START_3: begin
        r.scl_low = 1'b1;
        r.byte_index = s.byte_index + 3'd1;
        r = hold_f(r, i2crm_pkg::PH_NEXT, hv);
      end
      i2crm_pkg::PH_NEXT: begin
        if (s.lcmd == i2crm_pkg::CMD_WRITE) begin
          unique case (s.byte_index)
            3'd1:    r = wbyte_f(r, addr);
            3'd2:    r = wbyte_f(r, s.lptr);
            3'd3:    r = wbyte_f(r, s.ldata[15:8]);
            3'd4:    r = wbyte_f(r, s.ldata[7:0]);
            default: begin
              r.status = i2crm_pkg::ST_OK;
              r = go_f(r, i2crm_pkg::PH_STOP);
            end
          endcase
        end else begin
          unique case (s.byte_index)
            3'd1:      r = wbyte_f(r, addr);
            3'd2:      r = wbyte_f(r, s.lptr);
            3'd3:      r = go_f(r, i2crm_pkg::PH_START_BEGIN);
            3'd4:      r = wbyte_f(r, addr | 8'h01);
            3'd5, 3'd6: r = go_f(r, i2crm_pkg::PH_RB_BEGIN);
            default: begin
              r.status = i2crm_pkg::ST_OK;
              r = go_f(r, i2crm_pkg::PH_STOP);
            end
          endcase
        end
      end
      i2crm_pkg::PH_WB_BEGIN: begin
        r.bit_count = 4'd0;
        r = go_f(r, i2crm_pkg::PH_WB_BIT);
      end
      i2crm_pkg::PH_WB_BIT: begin
        r.sda_low = ~s.shift_byte[7];
        r = hold_f(r, i2crm_pkg::PH_WB_CLK, hv);
      end
      i2crm_pkg::PH_WB_CLK: r = rel_f(r, i2crm_pkg::PH_WB_CLKED);
      i2crm_pkg::PH_WB_CLKED: begin
        if (s.stretch_fail) begin
          r.status = i2crm_pkg::ST_TIMEOUT;
          r = go_f(r, i2crm_pkg::PH_STOP);
        end else begin
          r.scl_low = 1'b1;
          r = hold_f(r, i2crm_pkg::PH_WB_AFTER, hv);
        end
      end
      i2crm_pkg::PH_WB_AFTER: begin
        r.bit_count = s.bit_count + 4'd1;
        r.shift_byte = {s.shift_byte[6:0], 1'b0};
        if (r.bit_count < 4'd8) begin
          r = go_f(r, i2crm_pkg::PH_WB_BIT);
        end else begin
          r.sda_low = 1'b0;
          r = hold_f(r, i2crm_pkg::PH_ACK_CLK, hv);
        end
      end
      i2crm_pkg::PH_ACK_CLK: r = rel_f(r, i2crm_pkg::PH_ACK_SAMPLE);
      i2crm_pkg::PH_ACK_SAMPLE: begin
        if (s.stretch_fail) begin
          r.status = i2crm_pkg::ST_TIMEOUT;
          r = go_f(r, i2crm_pkg::PH_STOP);
        end else begin
          if (sda) r.status = i2crm_pkg::ST_NACK;
          r.scl_low = 1'b1;
          r = hold_f(r, i2crm_pkg::PH_ACK_DONE, hv);
        end
      end
      i2crm_pkg::PH_ACK_DONE: begin
        if (s.status != i2crm_pkg::ST_OK) begin
          r = go_f(r, i2crm_pkg::PH_STOP);
        end else begin
          r.byte_index = s.byte_index + 3'd1;
          r = go_f(r, i2crm_pkg::PH_NEXT);
        end
      end
      i2crm_pkg::PH_RB_BEGIN: begin
        r.sda_low = 1'b0;
        r.bit_count = 4'd0;
        r.shift_byte = 8'd0;
        r = go_f(r, i2crm_pkg::PH_RB_CLK);
      end
      i2crm_pkg::PH_RB_CLK: r = rel_f(r, i2crm_pkg::PH_RB_SAMPLE);
      i2crm_pkg::PH_RB_SAMPLE: begin
        if (s.stretch_fail) begin
          r.status = i2crm_pkg::ST_TIMEOUT;
          r = go_f(r, i2crm_pkg::PH_STOP);
        end else begin
          r.shift_byte = {s.shift_byte[6:0], sda};
          r.scl_low = 1'b1;
          r = hold_f(r, i2crm_pkg::PH_RB_AFTER, hv);
        end
      end
      i2crm_pkg::PH_RB_AFTER: begin
        r.bit_count = s.bit_count + 4'd1;
        if (r.bit_count < 4'd8) begin
          r = go_f(r, i2crm_pkg::PH_RB_CLK);
        end else begin
          // ACK the MSB, NACK the LSB
          r.sda_low = (s.byte_index == 3'd5);
          r = hold_f(r, i2crm_pkg::PH_RB_ACLK, hv);
        end
      end
      i2crm_pkg::PH_RB_ACLK: r = rel_f(r, i2crm_pkg::PH_RB_ADONE);
      i2crm_pkg::PH_RB_ADONE: begin
        if (s.stretch_fail) begin
          r.status = i2crm_pkg::ST_TIMEOUT;
          r = go_f(r, i2crm_pkg::PH_STOP);
        end else begin
          if (s.byte_index == 3'd5) r.ldata = {s.shift_byte, 8'd0};
          else                      r.ldata = {s.ldata[15:8], s.shift_byte};
          r.scl_low = 1'b1;
          r = hold_f(r, i2crm_pkg::PH_RB_END, hv);
        end
      end
      i2crm_pkg::PH_RB_END: begin
        r.sda_low = 1'b0;
        r.byte_index = s.byte_index + 3'd1;
        r = go_f(r, i2crm_pkg::PH_NEXT);
      end
      i2crm_pkg::PH_STOP: begin
        r.sda_low = 1'b1;
        r = hold_f(r, i2crm_pkg::PH_STOP_2, hv);
      end
      i2crm_pkg::PH_STOP_2: r = rel_f(r, i2crm_pkg::PH_STOP_3);
      i2crm_pkg::PH_STOP_3: begin
        r.sda_low = 1'b0;
        r = hold_f(r, i2crm_pkg::PH_FINISH, hv);
      end
      i2crm_pkg::PH_FINISH: begin
        if (s.lcmd == i2crm_pkg::CMD_READ && s.status == i2crm_pkg::ST_OK) r.rxval = s.ldata;
        r.done = 1'b1;
        r.timing = i2crm_pkg::TM_IDLE;
        r.phase = i2crm_pkg::PH_IDLE;
      end
      i2crm_pkg::PH_RC_BEGIN: begin
        r.sda_low = 1'b0;
        r.bit_count = 4'd0;
        r = go_f(r, i2crm_pkg::PH_RC_TEST);
      end
      i2crm_pkg::PH_RC_TEST: begin
        if (s.bit_count >= 4'd9 || sda) r = go_f(r, i2crm_pkg::PH_STOP);
        else                            r = rel_f(r, i2crm_pkg::PH_RC_CLKED);
      end
      i2crm_pkg::PH_RC_CLKED: begin
        if (s.stretch_fail) begin
          r.status = i2crm_pkg::ST_TIMEOUT;
          r = go_f(r, i2crm_pkg::PH_STOP);
        end else begin
          r.scl_low = 1'b1;
          r = hold_f(r, i2crm_pkg::PH_RC_AFTER, hv);
        end
      end
      i2crm_pkg::PH_RC_AFTER: begin
        r.bit_count = s.bit_count + 4'd1;
        r = go_f(r, i2crm_pkg::PH_RC_TEST);
      end
      default: begin
        r.timing = i2crm_pkg::TM_IDLE;
        r.phase = i2crm_pkg::PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // Next state: advance timing, then chain the actions of this tick
  always_comb begin
    seq_state_t s;
    s = st_r;
    s.done = 1'b0;
    unique case (st_r.timing)
      i2crm_pkg::TM_IDLE: begin
        if (in_word.command != i2crm_pkg::CMD_NONE) begin
          s.lcmd = in_word.command;
          s.lptr = in_word.register_pointer;
          s.ldata = (in_word.command == i2crm_pkg::CMD_WRITE) ? in_word.write_data : 16'd0;
          s.status = i2crm_pkg::ST_OK;
          s.byte_index = 3'd0;
          s.bit_count = 4'd0;
          s = go_f(s, (in_word.command == i2crm_pkg::CMD_RECOVER) ?
                      i2crm_pkg::PH_RC_BEGIN : i2crm_pkg::PH_START_BEGIN);
        end
      end
      i2crm_pkg::TM_DELAY: begin
        if (st_r.tick_timer <= 16'd1) s.timing = i2crm_pkg::TM_RUN;
        else s.tick_timer = st_r.tick_timer - 16'd1;
      end
      i2crm_pkg::TM_WAIT: begin
        if (in_word.scl_in) begin
          s.stretch_fail = 1'b0;
          s = hold_f(s, st_r.phase, hold_val);
        end else if ({1'b0, st_r.tick_timer} + 17'd1 >= {1'b0, limit}) begin
          s.stretch_fail = 1'b1;
          s = hold_f(s, st_r.phase, hold_val);
        end else begin
          s.tick_timer = st_r.tick_timer + 16'd1;
        end
      end
      default: s.timing = i2crm_pkg::TM_RUN;
    endcase
    // at most four actions chain in one tick
    for (int k = 0; k < 4; k++) begin
      if (s.timing == i2crm_pkg::TM_RUN)
        s = run_action(s, in_word.sda_in, cfg.device_address, hold_val);
    end
    st_nxt = s;
  end

  // Outputs: result word from the updated state
  always_comb begin
    res_nxt.scl_drive_low = st_nxt.scl_low;
    res_nxt.sda_drive_low = st_nxt.sda_low;
    res_nxt.busy_res      = (st_nxt.timing != i2crm_pkg::TM_IDLE);
    res_nxt.done_res      = st_nxt.done;
    res_nxt.read_value    = st_nxt.rxval;
    res_nxt.status        = st_nxt.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/i2c_register_master_unit.sv @@
`default_nettype none
// Open-drain I2C master for 16-bit register writes, register reads and bus
// recovery. Every accepted input word is one timing tick of the bus: the
// sequencer advances one tick and returns one result word with the line
// drives, busy, done, status and the last read value. One word is taken per
// cycle; its result appears in the output register on the next cycle, and
// input is stalled only while that register is full and held by out_stall.
// Bus timing is counted in words, not clocks: half_period_ticks per phase.
module i2c_register_master_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire i2crm_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output i2crm_pkg::out_word_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  i2crm_pkg::cfg_t      cfg_r;
  i2crm_pkg::out_word_t res_nxt;
  i2crm_pkg::out_word_t out_data_r;
  logic                 out_valid_r;
  logic                 in_acc;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks     <= i2crm_pkg::HALF_PERIOD_RST;
      cfg_r.stretch_timeout_ticks <= i2crm_pkg::STRETCH_TO_RST;
      cfg_r.device_address        <= i2crm_pkg::DEV_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2crm_pkg::CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata[9:0];
        i2crm_pkg::CFG_STRETCH_TO:  cfg_r.stretch_timeout_ticks <= cfg_wdata;
        i2crm_pkg::CFG_DEV_ADDR:    cfg_r.device_address <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  i2crm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (in_acc),
    .in_word (in_data),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  // Load the result word; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ hdl/i2crm_checker.sv @@
`default_nettype none
`include "i2c_register_master_unit_macros.svh"
module i2crm_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire i2crm_pkg::out_word_t out_data
);

  // a held result word keeps its value
  `I2CRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result word changed under stall")

  // input backs up only behind a held result
  `I2CRM_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without held result")

  // done ends the transaction
  `I2CRM_ASSERT_NOW(a_done_idle, clk, rst_n, out_valid && out_data.done_res, !out_data.busy_res, "done while busy")

  // idle master leaves both lines released
  `I2CRM_ASSERT_NOW(a_idle_release, clk, rst_n, out_valid && !out_data.busy_res, !out_data.scl_drive_low && !out_data.sda_drive_low, "line driven while idle")

endmodule

bind i2c_register_master_unit i2crm_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import i2crm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_HALF_PERIOD;
  logic [15:0] cfg_wdata = '0;

  i2c_register_master_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bus sequencer shadow: configuration
  logic [9:0] half_r = HALF_PERIOD_RST;
  logic [15:0] stretch_r = STRETCH_TO_RST;
  logic [6:0] addr_r = DEV_ADDR_RST;

  // Bus sequencer shadow: state
  phase_t ph = PH_IDLE;
  timing_t tm = TM_IDLE;
  logic [3:0] bit_cnt = '0;
  logic [2:0] byte_idx = '0;
  logic [7:0] shreg = '0;
  int unsigned tick_ctr = 0;
  logic [1:0] l_cmd = CMD_NONE;
  logic [7:0] l_ptr = '0;
  logic [15:0] l_data = '0;
  logic [15:0] rd_val = '0;
  status_t bus_status = ST_OK;
  logic stretch_fail = 1'b0;
  logic scl_low = 1'b0;
  logic sda_low = 1'b0;
  logic done_pulse = 1'b0;

  in_word_t tick_q[$];
  out_word_t line_q[$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_cnt = 0;
  int unsigned cyc = 0;
  logic in_took = 1'b0;

  function automatic void tm_go(phase_t nxt);
    tm = TM_RUN;
    ph = nxt;
  endfunction

  function automatic void tm_hold(phase_t nxt);
    tick_ctr = (half_r == 10'd0) ? 1 : {22'd0, half_r};
    tm = TM_DELAY;
    ph = nxt;
  endfunction

  function automatic void scl_release(phase_t nxt);
    scl_low = 1'b0;
    tick_ctr = 0;
    stretch_fail = 1'b0;
    tm = TM_WAIT;
    ph = nxt;
  endfunction

  function automatic void scl_pull(phase_t nxt);
    scl_low = 1'b1;
    tm_hold(nxt);
  endfunction

  function automatic void fail_stop(status_t code);
    bus_status = code;
    tm_go(PH_STOP);
  endfunction

  function automatic void send_byte(logic [7:0] b);
    shreg = b;
    tm_go(PH_WB_BEGIN);
  endfunction

  // Pick the next byte or step of the transaction
  function automatic void next_step();
    logic [7:0] ab;
    ab = {addr_r, 1'b0};
    if (l_cmd == CMD_WRITE) begin
      case (byte_idx)
        3'd1: send_byte(ab);
        3'd2: send_byte(l_ptr);
        3'd3: send_byte(l_data[15:8]);
        3'd4: send_byte(l_data[7:0]);
        default: begin bus_status = ST_OK; tm_go(PH_STOP); end
      endcase
    end else begin
      case (byte_idx)
        3'd1: send_byte(ab);
        3'd2: send_byte(l_ptr);
        3'd3: tm_go(PH_START_BEGIN);
        3'd4: send_byte(ab | 8'h01);
        3'd5, 3'd6: tm_go(PH_RB_BEGIN);
        default: begin bus_status = ST_OK; tm_go(PH_STOP); end
      endcase
    end
  endfunction

  function automatic void run_step(logic sda);
    case (ph)
      PH_START_BEGIN: begin sda_low = 1'b0; scl_release(PH_START_2); end
      PH_START_2: begin
        if (stretch_fail) begin
          bus_status = ST_TIMEOUT;
          if (byte_idx == 3'd0) tm_go(PH_FINISH); else tm_go(PH_STOP);
        end else begin
          sda_low = 1'b1;
          tm_hold(PH_START_3);
        end
      end
      PH_START_3: begin scl_pull(PH_NEXT); byte_idx = byte_idx + 3'd1; end
      PH_NEXT: next_step();
      PH_WB_BEGIN: begin bit_cnt = 4'd0; tm_go(PH_WB_BIT); end
      PH_WB_BIT: begin sda_low = !shreg[7]; tm_hold(PH_WB_CLK); end
      PH_WB_CLK: scl_release(PH_WB_CLKED);
      PH_WB_CLKED: if (stretch_fail) fail_stop(ST_TIMEOUT); else scl_pull(PH_WB_AFTER);
      PH_WB_AFTER: begin
        bit_cnt = bit_cnt + 4'd1;
        shreg = {shreg[6:0], 1'b0};
        if (bit_cnt < 4'd8) tm_go(PH_WB_BIT);
        else begin sda_low = 1'b0; tm_hold(PH_ACK_CLK); end
      end
      PH_ACK_CLK: scl_release(PH_ACK_SAMPLE);
      PH_ACK_SAMPLE: begin
        if (stretch_fail) fail_stop(ST_TIMEOUT);
        else begin
          if (sda) bus_status = ST_NACK;
          scl_pull(PH_ACK_DONE);
        end
      end
      PH_ACK_DONE: begin
        if (bus_status != ST_OK) tm_go(PH_STOP);
        else begin byte_idx = byte_idx + 3'd1; tm_go(PH_NEXT); end
      end
      PH_RB_BEGIN: begin
        sda_low = 1'b0; bit_cnt = 4'd0; shreg = '0;
        tm_go(PH_RB_CLK);
      end
      PH_RB_CLK: scl_release(PH_RB_SAMPLE);
      PH_RB_SAMPLE: begin
        if (stretch_fail) fail_stop(ST_TIMEOUT);
        else begin shreg = {shreg[6:0], sda}; scl_pull(PH_RB_AFTER); end
      end
      PH_RB_AFTER: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt < 4'd8) tm_go(PH_RB_CLK);
        else begin sda_low = (byte_idx == 3'd5); tm_hold(PH_RB_ACLK); end
      end
      PH_RB_ACLK: scl_release(PH_RB_ADONE);
      PH_RB_ADONE: begin
        if (stretch_fail) fail_stop(ST_TIMEOUT);
        else begin
          if (byte_idx == 3'd5) l_data = {shreg, 8'h00};
          else l_data = {l_data[15:8], shreg};
          scl_pull(PH_RB_END);
        end
      end
      PH_RB_END: begin sda_low = 1'b0; byte_idx = byte_idx + 3'd1; tm_go(PH_NEXT); end
      PH_STOP: begin sda_low = 1'b1; tm_hold(PH_STOP_2); end
      PH_STOP_2: scl_release(PH_STOP_3);
      PH_STOP_3: begin sda_low = 1'b0; tm_hold(PH_FINISH); end
      PH_FINISH: begin
        if (l_cmd == CMD_READ && bus_status == ST_OK) rd_val = l_data;
        done_pulse = 1'b1;
        tm = TM_IDLE;
        ph = PH_IDLE;
      end
      PH_RC_BEGIN: begin sda_low = 1'b0; bit_cnt = 4'd0; tm_go(PH_RC_TEST); end
      PH_RC_TEST: begin
        if (bit_cnt >= 4'd9 || sda) tm_go(PH_STOP);
        else scl_release(PH_RC_CLKED);
      end
      PH_RC_CLKED: if (stretch_fail) fail_stop(ST_TIMEOUT); else scl_pull(PH_RC_AFTER);
      PH_RC_AFTER: begin bit_cnt = bit_cnt + 4'd1; tm_go(PH_RC_TEST); end
      default: begin tm = TM_IDLE; ph = PH_IDLE; end
    endcase
  endfunction

  // Advance the bus sequencer by one tick and return the line levels
  function automatic out_word_t bus_tick(in_word_t w);
    out_word_t r;
    int unsigned lim;
    int guard;
    lim = (stretch_r == 16'd0) ? 1 : {16'd0, stretch_r};
    guard = 64;
    done_pulse = 1'b0;
    case (tm)
      TM_IDLE: begin
        if (w.command != CMD_NONE) begin
          l_cmd = w.command;
          l_ptr = w.register_pointer;
          l_data = (w.command == CMD_WRITE) ? w.write_data : 16'h0000;
          bus_status = ST_OK;
          byte_idx = 3'd0;
          bit_cnt = 4'd0;
          tm_go(w.command == CMD_RECOVER ? PH_RC_BEGIN : PH_START_BEGIN);
        end
      end
      TM_DELAY: if (tick_ctr <= 1) tm = TM_RUN; else tick_ctr--;
      TM_WAIT: begin
        if (w.scl_in) begin
          stretch_fail = 1'b0;
          tm_hold(ph);
        end else if (tick_ctr + 1 >= lim) begin
          stretch_fail = 1'b1;
          tm_hold(ph);
        end else begin
          tick_ctr++;
        end
      end
      default: tm = TM_RUN;
    endcase
    while (tm == TM_RUN && guard > 0) begin
      run_step(w.sda_in);
      guard--;
    end
    r.scl_drive_low = scl_low;
    r.sda_drive_low = sda_low;
    r.busy_res = (tm != TM_IDLE);
    r.done_res = done_pulse;
    r.read_value = rd_val;
    r.status = bus_status;
    return r;
  endfunction

  // Drive input words and receiver stall at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data <= tick_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Predict on accepted words, check accepted results
  always @(posedge clk) begin
    out_word_t e;
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("FAIL i2c_register_master_unit");
      $finish;
    end else if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) line_q.push_back(bus_tick(in_data));
      if (out_valid && !out_stall) begin
        if (line_q.size() == 0) begin
          $error("result word with no expectation");
          fail_cnt++;
        end else begin
          e = line_q.pop_front();
          if (out_data.scl_drive_low !== e.scl_drive_low) begin
            $error("scl_drive_low exp %0d got %0d", e.scl_drive_low, out_data.scl_drive_low);
            fail_cnt++;
          end
          if (out_data.sda_drive_low !== e.sda_drive_low) begin
            $error("sda_drive_low exp %0d got %0d", e.sda_drive_low, out_data.sda_drive_low);
            fail_cnt++;
          end
          if (out_data.busy_res !== e.busy_res) begin
            $error("busy_res exp %0d got %0d", e.busy_res, out_data.busy_res);
            fail_cnt++;
          end
          if (out_data.done_res !== e.done_res) begin
            $error("done_res exp %0d got %0d", e.done_res, out_data.done_res);
            fail_cnt++;
          end
          if (out_data.read_value !== e.read_value) begin
            $error("read_value exp %h got %h", e.read_value, out_data.read_value);
            fail_cnt++;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            fail_cnt++;
          end
        end
      end
    end
  end

  function automatic in_word_t make_tick(logic [1:0] cmd, logic scl, logic sda);
    in_word_t w;
    w.command = cmd;
    w.register_pointer = 8'($urandom_range(255));
    w.write_data = 16'($urandom_range(65535));
    w.scl_in = scl;
    w.sda_in = sda;
    return w;
  endfunction

  // Queue random ticks: command rate, SCL-held-low rate, SDA-high rate
  task automatic push_ticks(int n, int cmd_pct, int scl_low_pct, int sda_hi_pct);
    for (int i = 0; i < n; i++) begin
      tick_q.push_back(make_tick(
        ($urandom_range(99) < cmd_pct) ? 2'($urandom_range(3)) : CMD_NONE,
        $urandom_range(99) >= scl_low_pct, $urandom_range(99) < sda_hi_pct));
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() > 0 || in_valid || line_q.size() > 0) @(negedge clk);
  endtask

  // Let any transaction run out on a quiet bus, then settle
  task automatic drain_bus();
    wait_drained();
    while (tm != TM_IDLE) begin
      for (int i = 0; i < 64; i++) tick_q.push_back(make_tick(CMD_NONE, 1'b1, 1'b1));
      wait_drained();
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_HALF_PERIOD: half_r = val[9:0];
      CFG_STRETCH_TO: stretch_r = val;
      default: addr_r = val[6:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_cfg(logic [15:0] hp, logic [15:0] to, logic [15:0] ad);
    cfg_write(CFG_HALF_PERIOD, hp);
    cfg_write(CFG_STRETCH_TO, to);
    cfg_write(CFG_DEV_ADDR, ad);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: recovery on a free bus, short
    tick_q.push_back(make_tick(CMD_RECOVER, 1'b1, 1'b1));
    drain_bus();

    // Zero half period and timeout, top address
    set_cfg(16'd0, 16'd0, 16'd127);
    // write with extreme values, all ACKed
    tick_q.push_back('{command: CMD_WRITE, register_pointer: 8'hFF,
                       write_data: 16'hFFFF, scl_in: 1'b1, sda_in: 1'b0});
    push_ticks(200, 0, 0, 0);
    drain_bus();
    tick_q.push_back('{command: CMD_WRITE, register_pointer: 8'h00,
                       write_data: 16'h0000, scl_in: 1'b1, sda_in: 1'b0});
    push_ticks(200, 0, 0, 0);
    drain_bus();
    // read with random data bits
    tick_q.push_back(make_tick(CMD_READ, 1'b1, 1'b0));
    push_ticks(250, 0, 0, 30);
    drain_bus();
    // address NACK
    tick_q.push_back(make_tick(CMD_WRITE, 1'b1, 1'b1));
    drain_bus();
    // stuck SDA: nine recovery clocks
    tick_q.push_back(make_tick(CMD_RECOVER, 1'b1, 1'b0));
    push_ticks(60, 0, 0, 0);
    drain_bus();
    // stretch timeout on the first start
    tick_q.push_back(make_tick(CMD_READ, 1'b0, 1'b0));
    push_ticks(6, 0, 100, 0);
    drain_bus();
    // stretch timeout inside a byte
    tick_q.push_back(make_tick(CMD_WRITE, 1'b1, 1'b0));
    push_ticks(20, 0, 0, 0);
    push_ticks(6, 0, 100, 0);
    drain_bus();

    // Random phases
    set_cfg(16'd1, 16'd4, 16'($urandom_range(127)));
    idle_pct = 0; stall_pct = 0;
    push_ticks(150, 20, 10, 10);
    wait_drained();
    push_ticks(150, 20, 10, 10);
    drain_bus();

    set_cfg(16'd2, 16'd65535, 16'd0);
    idle_pct = 48; stall_pct = 0;
    push_ticks(250, 20, 5, 15);
    drain_bus();

    set_cfg(16'd1, 16'd1, 16'($urandom_range(127)));
    idle_pct = 0; stall_pct = 48;
    push_ticks(250, 20, 3, 15);
    drain_bus();

    set_cfg(16'd3, 16'd2, 16'd127);
    idle_pct = 26; stall_pct = 26;
    push_ticks(300, 15, 15, 30);
    drain_bus();

    idle_pct = 0; stall_pct = 0;
    repeat (20) @(negedge clk);
    if (fail_cnt == 0 && line_q.size() == 0) begin
      $display("PASS i2c_register_master_unit");
    end else begin
      $display("FAIL i2c_register_master_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
